// ===== design/lpbt_pkg.sv =====
// ============================================================================
// lpbt_pkg
// shared constants and types for the lidar point projection and box test
// ============================================================================
package lpbt_pkg;

    // sizes of the block
    localparam int MAX_BOXES  = 16;
    localparam int PIXEL_BITS = 12;
    localparam int PIX_W      = PIXEL_BITS + 1;
    localparam int PIX_MAX    = (1 << PIXEL_BITS) - 1;
    localparam int PIX_MIN    = -(1 << PIXEL_BITS);
    localparam int BOX_W      = 12;
    localparam int HIT_W      = 16;
    localparam int HIT_N      = (MAX_BOXES < HIT_W) ? MAX_BOXES : HIT_W;
    localparam int CNT_W      = $clog2(MAX_BOXES + 1);
    localparam int BIDX_W     = (MAX_BOXES > 1) ? $clog2(MAX_BOXES) : 1;
    localparam int CMP_W      = ((PIX_W > BOX_W) ? PIX_W : BOX_W) + 1;

    // register port
    localparam int CFG_W      = 63;
    localparam int CFG_IDX_W  = 3;
    localparam logic [CFG_IDX_W-1:0] CFG_ROT0  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ROT1  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ROT2  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_TRANS = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_INTR  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_INTC  = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_RAD   = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_TANH  = 3'd7;

    // commands
    localparam logic [1:0] CMD_CLEAR   = 2'd0;
    localparam logic [1:0] CMD_APPEND  = 2'd1;
    localparam logic [1:0] CMD_PROJECT = 2'd2;
    localparam logic [1:0] CMD_NONE    = 2'd3;

    // result status
    localparam logic [2:0] STS_PROJ    = 3'd0;
    localparam logic [2:0] STS_HIGH    = 3'd1;
    localparam logic [2:0] STS_BEHIND  = 3'd2;
    localparam logic [2:0] STS_STORED  = 3'd3;
    localparam logic [2:0] STS_FULL    = 3'd4;
    localparam logic [2:0] STS_CLEARED = 3'd5;

    // divider
    localparam int FRAC      = 20;
    localparam int MAG_W     = 48;
    localparam int REM_W     = MAG_W + 2;
    localparam int Q_W       = FRAC + 2;
    localparam int NQ_W      = Q_W + 1;
    localparam int DIV_STEPS = Q_W;

    // pipeline stage numbers
    localparam int STG_IN    = 0;
    localparam int STG_MUL   = 1;
    localparam int STG_SUM   = 2;
    localparam int STG_PREP  = 3;
    localparam int STG_QUO   = STG_PREP + DIV_STEPS + 1;
    localparam int STG_SQ    = STG_QUO + 1;
    localparam int STG_R2    = STG_SQ + 1;
    localparam int STG_R4    = STG_R2 + 1;
    localparam int STG_R6    = STG_R4 + 1;
    localparam int STG_K3    = STG_R6 + 1;
    localparam int STG_RAD   = STG_K3 + 1;
    localparam int STG_XR    = STG_RAD + 1;
    localparam int STG_XD    = STG_XR + 1;
    localparam int STG_PMUL  = STG_XD + 1;
    localparam int STG_PIX   = STG_PMUL + 1;
    localparam int PIPE_DEPTH = STG_PIX + 1;

    typedef struct packed {
        logic [BOX_W-1:0] top;
        logic [BOX_W-1:0] bottom;
        logic [BOX_W-1:0] left;
        logic [BOX_W-1:0] right;
    } t_box;

    // control word that travels with each item
    typedef struct packed {
        logic [1:0] cmd;
        logic       high;
        logic       behind;
        t_box       box;
    } t_tag;

endpackage

// ===== design/lpbt_div.sv =====
// ============================================================================
// lpbt_div
// pipelined restoring divider, one quotient bit per stage, q20 signed result
// ============================================================================
module lpbt_div
    import lpbt_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_en,
    input  logic [MAG_W-1:0]       i_mag,
    input  logic [MAG_W-1:0]       i_den,
    input  logic                   i_neg,
    output logic signed [NQ_W-1:0] o_quo
);

    logic [REM_W-1:0] r_rem [DIV_STEPS];
    logic [MAG_W-1:0] r_den [DIV_STEPS];
    logic [Q_W-1:0]   r_q   [DIV_STEPS];
    logic             r_neg [DIV_STEPS];
    logic             r_sat [DIV_STEPS];
    logic signed [NQ_W-1:0] r_quo;

    for (genvar k = 0; k < DIV_STEPS; k++) begin : g_step
        logic [REM_W-1:0] w_trial;
        logic [REM_W-1:0] w_dv;
        logic             w_ge;
        logic [MAG_W-1:0] w_den;
        logic [Q_W-1:0]   w_q;
        logic             w_neg;
        logic             w_sat;

        if (k == 0) begin : g_first
            // integer bit 1 and the range check
            assign w_trial = {2'b00, i_mag};
            assign w_dv    = {1'b0, i_den, 1'b0};
            assign w_den   = i_den;
            assign w_q     = '0;
            assign w_neg   = i_neg;
            assign w_sat   = ({2'b00, i_mag} >= {i_den, 2'b00});
        end else if (k == 1) begin : g_int
            assign w_trial = r_rem[k-1];
            assign w_dv    = {2'b00, r_den[k-1]};
            assign w_den   = r_den[k-1];
            assign w_q     = r_q[k-1];
            assign w_neg   = r_neg[k-1];
            assign w_sat   = r_sat[k-1];
        end else begin : g_frac
            assign w_trial = {r_rem[k-1][REM_W-2:0], 1'b0};
            assign w_dv    = {2'b00, r_den[k-1]};
            assign w_den   = r_den[k-1];
            assign w_q     = r_q[k-1];
            assign w_neg   = r_neg[k-1];
            assign w_sat   = r_sat[k-1];
        end

        assign w_ge = (w_trial >= w_dv);

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[k] <= w_ge ? (w_trial - w_dv) : w_trial;
                r_q[k]   <= {w_q[Q_W-2:0], w_ge};
                r_den[k] <= w_den;
                r_neg[k] <= w_neg;
                r_sat[k] <= w_sat;
            end
        end
    end

    // sign and saturation to [-4, 4 - 2^-20]
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            if (r_sat[DIV_STEPS-1]) begin
                r_quo <= r_neg[DIV_STEPS-1] ? {1'b1, {Q_W{1'b0}}} : {1'b0, {Q_W{1'b1}}};
            end else if (r_neg[DIV_STEPS-1]) begin
                r_quo <= -$signed({1'b0, r_q[DIV_STEPS-1]});
            end else begin
                r_quo <= $signed({1'b0, r_q[DIV_STEPS-1]});
            end
        end
    end

    assign o_quo = r_quo;

endmodule

// ===== design/lidar_point_camera_projection_box_test.sv =====
// ============================================================================
// lidar_point_camera_projection_box_test
// lidar point to camera pixel projection with lens distortion and box test
// ============================================================================
// One command word per cycle. Clear and append act on a table of up to 16
// pixel boxes; project rotates and translates a lidar point into the camera
// frame, divides by depth, applies radial (k1, k2, k3) and tangential (p1, p2)
// distortion and the intrinsic rows, floors to saturated pixels and reports
// which stored boxes hold the pixel. The pipeline is 37 register stages plus
// the output register, and a new word is taken every cycle while o_stall
// is low. The two depth dividers resolve one quotient bit per stage over
// 22 stages. Box commands travel the same pipeline and act on the table
// in the last stage, so every projected point sees exactly the boxes that
// preceded it. When a result sits unread and i_stall is high, the whole
// pipeline holds and o_stall is raised. Command code 3 is accepted and
// gives no result. Registers must only be written while the pipeline is
// empty, which the block itself does not enforce.
module lidar_point_camera_projection_box_test
    import lpbt_pkg::*;
(
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    // register port
    input  logic                    i_cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [CFG_W-1:0]        i_cfg_data,
    // input words
    input  logic                    i_valid,
    output logic                    o_stall,
    input  logic [1:0]              i_command,
    input  logic signed [31:0]      i_point_x,
    input  logic signed [31:0]      i_point_y,
    input  logic signed [31:0]      i_point_z,
    input  logic [BOX_W-1:0]        i_box_top,
    input  logic [BOX_W-1:0]        i_box_bottom,
    input  logic [BOX_W-1:0]        i_box_left,
    input  logic [BOX_W-1:0]        i_box_right,
    // result words
    output logic                    o_valid,
    input  logic                    i_stall,
    output logic [2:0]              o_status,
    output logic signed [PIX_W-1:0] o_pixel_row,
    output logic signed [PIX_W-1:0] o_pixel_col,
    output logic [HIT_W-1:0]        o_hit_mask
);

    // ------------------------------------------------------------------
    // configuration registers
    // ------------------------------------------------------------------
    logic [47:0]      r_cfg_rot [3];
    logic [47:0]      r_cfg_trans;
    logic [CFG_W-1:0] r_cfg_intr;
    logic [CFG_W-1:0] r_cfg_intc;
    logic [47:0]      r_cfg_rad;
    logic [47:0]      r_cfg_tanh;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_rot[0] <= '0;
            r_cfg_rot[1] <= '0;
            r_cfg_rot[2] <= '0;
            r_cfg_trans  <= '0;
            r_cfg_intr   <= '0;
            r_cfg_intc   <= '0;
            r_cfg_rad    <= '0;
            r_cfg_tanh   <= '0;
        end else if (i_cfg_wr_en) begin
            case (i_cfg_index)
                CFG_ROT0:  r_cfg_rot[0] <= i_cfg_data[47:0];
                CFG_ROT1:  r_cfg_rot[1] <= i_cfg_data[47:0];
                CFG_ROT2:  r_cfg_rot[2] <= i_cfg_data[47:0];
                CFG_TRANS: r_cfg_trans  <= i_cfg_data[47:0];
                CFG_INTR:  r_cfg_intr   <= i_cfg_data;
                CFG_INTC:  r_cfg_intc   <= i_cfg_data;
                CFG_RAD:   r_cfg_rad    <= i_cfg_data[47:0];
                CFG_TANH:  r_cfg_tanh   <= i_cfg_data[47:0];
                default:   r_cfg_tanh   <= r_cfg_tanh;
            endcase
        end
    end

    // unpacked coefficient fields
    logic signed [15:0] w_rot [3][3];
    logic signed [15:0] w_trans [3];
    logic signed [15:0] w_k1, w_k2, w_k3, w_p1, w_p2, w_hlim;
    logic signed [20:0] w_gain_r, w_skew_r, w_off_r;
    logic signed [20:0] w_gain_c, w_skew_c, w_off_c;
    logic signed [31:0] w_hlim_q16;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            for (int j = 0; j < 3; j++) begin
                w_rot[i][j] = r_cfg_rot[i][16*j +: 16];
            end
            w_trans[i] = r_cfg_trans[16*i +: 16];
        end
    end

    assign w_k1       = r_cfg_rad[15:0];
    assign w_k2       = r_cfg_rad[31:16];
    assign w_k3       = r_cfg_rad[47:32];
    assign w_p1       = r_cfg_tanh[15:0];
    assign w_p2       = r_cfg_tanh[31:16];
    assign w_hlim     = r_cfg_tanh[47:32];
    assign w_gain_r   = r_cfg_intr[20:0];
    assign w_skew_r   = r_cfg_intr[41:21];
    assign w_off_r    = r_cfg_intr[62:42];
    assign w_gain_c   = r_cfg_intc[20:0];
    assign w_skew_c   = r_cfg_intc[41:21];
    assign w_off_c    = r_cfg_intc[62:42];
    // height limit moved from q8.8 to the q16.16 of the point
    assign w_hlim_q16 = {{8{w_hlim[15]}}, w_hlim, 8'h00};

    // ------------------------------------------------------------------
    // flow control: the whole pipeline moves unless the result is held
    // ------------------------------------------------------------------
    logic r_out_valid;
    logic w_adv;

    assign w_adv   = !(r_out_valid && i_stall);
    assign o_stall = !w_adv;

    // valid bits and control words, one per stage
    logic r_vld [PIPE_DEPTH];
    t_tag r_tag [PIPE_DEPTH];
    t_tag n_tag [PIPE_DEPTH];

    // point at the input stage
    logic signed [31:0] r_p [3];
    // rotation products
    logic signed [47:0] r_prod [3][3];
    // camera coordinates, q30
    logic signed [49:0] r_c [3];
    logic signed [49:0] w_c [3];
    logic signed [49:0] w_trs [3];
    // divider operands
    logic [MAG_W-1:0]   r_mag_x, r_mag_y, r_den;
    logic               r_neg_x, r_neg_y;
    logic signed [NQ_W-1:0] w_qx, w_qy;

    // tag line, with the two drop checks written into it on the way
    always_comb begin
        n_tag[STG_IN].cmd    = i_command;
        n_tag[STG_IN].high   = 1'b0;
        n_tag[STG_IN].behind = 1'b0;
        n_tag[STG_IN].box    = '{top: i_box_top, bottom: i_box_bottom,
                                 left: i_box_left, right: i_box_right};
        for (int s = 1; s < PIPE_DEPTH; s++) begin
            n_tag[s] = r_tag[s-1];
            if (s == STG_MUL) begin
                n_tag[s].high = (r_p[2] > w_hlim_q16);
            end
            if (s == STG_PREP) begin
                n_tag[s].behind = (r_c[2] <= 50'sd0);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int s = 0; s < PIPE_DEPTH; s++) begin
                r_vld[s] <= 1'b0;
            end
        end else if (w_adv) begin
            // command 3 gives no result, so it never enters
            r_vld[STG_IN] <= i_valid && (i_command != CMD_NONE);
            for (int s = 1; s < PIPE_DEPTH; s++) begin
                r_vld[s] <= r_vld[s-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            for (int s = 0; s < PIPE_DEPTH; s++) begin
                r_tag[s] <= n_tag[s];
            end
        end
    end

    // ------------------------------------------------------------------
    // stages 0 to 3: capture, rotate, translate, divider operands
    // ------------------------------------------------------------------
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            w_trs[i] = {{16{w_trans[i][15]}}, w_trans[i], 18'h00000};
            w_c[i]   = r_prod[i][0] + r_prod[i][1] + r_prod[i][2] + w_trs[i];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_p[0] <= i_point_x;
            r_p[1] <= i_point_y;
            r_p[2] <= i_point_z;
            for (int i = 0; i < 3; i++) begin
                for (int j = 0; j < 3; j++) begin
                    r_prod[i][j] <= r_p[j] * w_rot[i][j];
                end
                r_c[i] <= w_c[i];
            end
            // magnitudes stay below 2^48 by the operand ranges
            r_neg_x <= r_c[0][49];
            r_neg_y <= r_c[1][49];
            r_mag_x <= r_c[0][49] ? MAG_W'(-r_c[0]) : r_c[0][MAG_W-1:0];
            r_mag_y <= r_c[1][49] ? MAG_W'(-r_c[1]) : r_c[1][MAG_W-1:0];
            r_den   <= r_c[2][MAG_W-1:0];
        end
    end

    // ------------------------------------------------------------------
    // depth division, normalized x and y in q20
    // ------------------------------------------------------------------
    lpbt_div u_div_x (
        .i_clk (i_clk),
        .i_en  (w_adv),
        .i_mag (r_mag_x),
        .i_den (r_den),
        .i_neg (r_neg_x),
        .o_quo (w_qx)
    );

    lpbt_div u_div_y (
        .i_clk (i_clk),
        .i_en  (w_adv),
        .i_mag (r_mag_y),
        .i_den (r_den),
        .i_neg (r_neg_y),
        .o_quo (w_qy)
    );

    // ------------------------------------------------------------------
    // distortion
    // ------------------------------------------------------------------
    // squares
    logic signed [45:0] w_sxx, w_syy, w_sxy;
    logic signed [25:0] r_sq_xx, r_sq_yy, r_sq_xy;
    logic signed [NQ_W-1:0] r_sq_x, r_sq_y;
    // r2
    logic signed [26:0] r_r2_r2;
    logic signed [25:0] r_r2_xx, r_r2_yy, r_r2_xy;
    logic signed [NQ_W-1:0] r_r2_x, r_r2_y;
    // r4 and tangential sums
    logic signed [53:0] w_r2sq;
    logic signed [31:0] r_r4_r4;
    logic signed [26:0] r_r4_r2;
    logic signed [27:0] r_r4_tx, r_r4_ty;
    logic signed [25:0] r_r4_xy;
    logic signed [NQ_W-1:0] r_r4_x, r_r4_y;
    // r6 and coefficient products
    logic signed [58:0] w_r4r2;
    logic signed [41:0] w_p1xy, w_p2xy;
    logic signed [36:0] r_r6_r6;
    logic signed [42:0] r_r6_kr2;
    logic signed [47:0] r_r6_kr4;
    logic signed [42:0] r_r6_ta1, r_r6_tb2;
    logic signed [43:0] r_r6_tb1, r_r6_ta2;
    logic signed [NQ_W-1:0] r_r6_x, r_r6_y;
    // k3 term and tangential offsets
    logic signed [44:0] w_tsx, w_tsy;
    logic signed [52:0] r_k3_kr6;
    logic signed [42:0] r_k3_kr2;
    logic signed [47:0] r_k3_kr4;
    logic signed [30:0] r_k3_tx, r_k3_ty;
    logic signed [NQ_W-1:0] r_k3_x, r_k3_y;
    // radial gain
    logic signed [54:0] w_rsum;
    logic signed [41:0] w_rad;
    logic signed [41:0] r_rad;
    logic signed [30:0] r_rad_tx, r_rad_ty;
    logic signed [NQ_W-1:0] r_rad_x, r_rad_y;
    // radial products
    logic signed [64:0] w_xr, w_yr;
    logic signed [44:0] r_xr, r_yr;
    logic signed [30:0] r_xr_tx, r_xr_ty;
    // distorted coordinates
    logic signed [45:0] r_xd, r_yd;

    assign w_sxx  = w_qx * w_qx;
    assign w_syy  = w_qy * w_qy;
    assign w_sxy  = w_qx * w_qy;
    assign w_r2sq = r_r2_r2 * r_r2_r2;
    assign w_r4r2 = r_r4_r4 * r_r4_r2;
    assign w_p1xy = w_p1 * r_r4_xy;
    assign w_p2xy = w_p2 * r_r4_xy;
    assign w_tsx  = r_r6_ta1 + r_r6_tb1;
    assign w_tsy  = r_r6_ta2 + r_r6_tb2;
    assign w_rsum = r_k3_kr2 + r_k3_kr4 + r_k3_kr6;
    assign w_rad  = 42'($signed(w_rsum[54:14])) + (42'sd1 <<< FRAC);
    assign w_xr   = r_rad_x * r_rad;
    assign w_yr   = r_rad_y * r_rad;

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            // xx, yy, xy floored to q20
            r_sq_xx <= w_sxx[45:20];
            r_sq_yy <= w_syy[45:20];
            r_sq_xy <= w_sxy[45:20];
            r_sq_x  <= w_qx;
            r_sq_y  <= w_qy;

            r_r2_r2 <= {r_sq_xx[25], r_sq_xx} + {r_sq_yy[25], r_sq_yy};
            r_r2_xx <= r_sq_xx;
            r_r2_yy <= r_sq_yy;
            r_r2_xy <= r_sq_xy;
            r_r2_x  <= r_sq_x;
            r_r2_y  <= r_sq_y;

            r_r4_r4 <= w_r2sq[51:20];
            r_r4_r2 <= r_r2_r2;
            r_r4_tx <= {r_r2_r2[26], r_r2_r2} + {r_r2_xx[25], r_r2_xx, 1'b0};
            r_r4_ty <= {r_r2_r2[26], r_r2_r2} + {r_r2_yy[25], r_r2_yy, 1'b0};
            r_r4_xy <= r_r2_xy;
            r_r4_x  <= r_r2_x;
            r_r4_y  <= r_r2_y;

            r_r6_r6  <= w_r4r2[56:20];
            r_r6_kr2 <= w_k1 * r_r4_r2;
            r_r6_kr4 <= w_k2 * r_r4_r4;
            r_r6_ta1 <= {w_p1xy, 1'b0};
            r_r6_tb1 <= w_p2 * r_r4_tx;
            r_r6_ta2 <= w_p1 * r_r4_ty;
            r_r6_tb2 <= {w_p2xy, 1'b0};
            r_r6_x   <= r_r4_x;
            r_r6_y   <= r_r4_y;

            r_k3_kr6 <= w_k3 * r_r6_r6;
            r_k3_kr2 <= r_r6_kr2;
            r_k3_kr4 <= r_r6_kr4;
            r_k3_tx  <= w_tsx[44:14];
            r_k3_ty  <= w_tsy[44:14];
            r_k3_x   <= r_r6_x;
            r_k3_y   <= r_r6_y;

            r_rad    <= w_rad;
            r_rad_tx <= r_k3_tx;
            r_rad_ty <= r_k3_ty;
            r_rad_x  <= r_k3_x;
            r_rad_y  <= r_k3_y;

            r_xr    <= w_xr[64:20];
            r_yr    <= w_yr[64:20];
            r_xr_tx <= r_rad_tx;
            r_xr_ty <= r_rad_ty;

            r_xd <= 46'(r_xr) + 46'(r_xr_tx);
            r_yd <= 46'(r_yr) + 46'(r_xr_ty);
        end
    end

    // ------------------------------------------------------------------
    // intrinsic rows and pixel saturation
    // ------------------------------------------------------------------
    logic signed [66:0] r_pa, r_pb, r_pc, r_pd;
    logic signed [68:0] w_rsum_pix, w_csum_pix;
    logic signed [40:0] w_rowf, w_colf;
    logic signed [PIX_W-1:0] r_row, r_col;

    assign w_rsum_pix = 69'(r_pa) + 69'(r_pb) + (69'(w_off_r) <<< FRAC);
    assign w_csum_pix = 69'(r_pc) + 69'(r_pd) + (69'(w_off_c) <<< FRAC);
    assign w_rowf     = w_rsum_pix[68:28];
    assign w_colf     = w_csum_pix[68:28];

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_pa <= w_gain_r * r_xd;
            r_pb <= w_skew_r * r_yd;
            r_pc <= w_gain_c * r_yd;
            r_pd <= w_skew_c * r_xd;

            if (w_rowf > 41'(PIX_MAX)) begin
                r_row <= PIX_W'(PIX_MAX);
            end else if (w_rowf < 41'(PIX_MIN)) begin
                r_row <= PIX_W'(PIX_MIN);
            end else begin
                r_row <= PIX_W'(w_rowf);
            end
            if (w_colf > 41'(PIX_MAX)) begin
                r_col <= PIX_W'(PIX_MAX);
            end else if (w_colf < 41'(PIX_MIN)) begin
                r_col <= PIX_W'(PIX_MIN);
            end else begin
                r_col <= PIX_W'(w_colf);
            end
        end
    end

    // ------------------------------------------------------------------
    // last stage: box table, hit test, result register
    // ------------------------------------------------------------------
    t_box             r_box [MAX_BOXES];
    logic [CNT_W-1:0] r_box_cnt;
    t_tag             w_ltag;
    logic             w_full;
    logic             w_proj;
    logic [2:0]       w_status;
    logic [HIT_W-1:0] w_hit;
    logic signed [CMP_W-1:0] w_row_c, w_col_c;

    logic [2:0]              r_status;
    logic signed [PIX_W-1:0] r_out_row, r_out_col;
    logic [HIT_W-1:0]        r_hit;

    assign w_ltag  = r_tag[PIPE_DEPTH-1];
    assign w_full  = (r_box_cnt >= CNT_W'(MAX_BOXES));
    assign w_row_c = CMP_W'(r_row);
    assign w_col_c = CMP_W'(r_col);

    always_comb begin
        case (w_ltag.cmd)
            CMD_CLEAR:  w_status = STS_CLEARED;
            CMD_APPEND: w_status = w_full ? STS_FULL : STS_STORED;
            CMD_PROJECT: begin
                if (w_ltag.high) begin
                    w_status = STS_HIGH;
                end else if (w_ltag.behind) begin
                    w_status = STS_BEHIND;
                end else begin
                    w_status = STS_PROJ;
                end
            end
            default:    w_status = STS_PROJ;
        endcase
    end

    assign w_proj = (w_ltag.cmd == CMD_PROJECT) && (w_status == STS_PROJ);

    always_comb begin
        w_hit = '0;
        for (int j = 0; j < HIT_N; j++) begin
            w_hit[j] = w_proj && (CNT_W'(j) < r_box_cnt)
                && (w_row_c >= $signed(CMP_W'(r_box[j].top)))
                && (w_row_c <  $signed(CMP_W'(r_box[j].bottom)))
                && (w_col_c >= $signed(CMP_W'(r_box[j].left)))
                && (w_col_c <  $signed(CMP_W'(r_box[j].right)));
        end
    end

    // control: result valid and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_box_cnt   <= '0;
        end else if (w_adv) begin
            r_out_valid <= r_vld[PIPE_DEPTH-1];
            if (r_vld[PIPE_DEPTH-1]) begin
                if (w_ltag.cmd == CMD_CLEAR) begin
                    r_box_cnt <= '0;
                end else if (w_ltag.cmd == CMD_APPEND && !w_full) begin
                    r_box_cnt <= r_box_cnt + 1'b1;
                end
            end
        end
    end

    // payload: table entries and result word
    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            if (r_vld[PIPE_DEPTH-1] && w_ltag.cmd == CMD_APPEND && !w_full) begin
                r_box[r_box_cnt[BIDX_W-1:0]] <= w_ltag.box;
            end
            r_status  <= w_status;
            r_out_row <= w_proj ? r_row : '0;
            r_out_col <= w_proj ? r_col : '0;
            r_hit     <= w_hit;
        end
    end

    assign o_valid     = r_out_valid;
    assign o_status    = r_status;
    assign o_pixel_row = r_out_row;
    assign o_pixel_col = r_out_col;
    assign o_hit_mask  = r_hit;

endmodule

// ===== design/lpbt_chk.sv =====
// ============================================================================
// lpbt_chk
// port-level checks on the projection block, bound to the top level
// ============================================================================
module lpbt_chk
    import lpbt_pkg::*;
(
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    o_stall,
    input  logic                    o_valid,
    input  logic                    i_stall,
    input  logic [2:0]              o_status,
    input  logic signed [PIX_W-1:0] o_pixel_row,
    input  logic signed [PIX_W-1:0] o_pixel_col,
    input  logic [HIT_W-1:0]        o_hit_mask
);

    // held result word stays put
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_status)
            && $stable(o_pixel_row) && $stable(o_pixel_col) && $stable(o_hit_mask))
        else $error("held result word changed");

    // input backpressure only comes from a held result
    a_stall_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> o_valid && i_stall)
        else $error("stall raised without a held result");

    // anything but a projected point carries zero pixel and hit fields
    a_zero_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_status != STS_PROJ) |->
            o_pixel_row == '0 && o_pixel_col == '0 && o_hit_mask == '0)
        else $error("nonzero fields on a non-projected word");

    // reset empties the result register
    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result valid right after reset");

endmodule

bind lidar_point_camera_projection_box_test lpbt_chk u_lpbt_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_stall     (o_stall),
    .o_valid     (o_valid),
    .i_stall     (i_stall),
    .o_status    (o_status),
    .o_pixel_row (o_pixel_row),
    .o_pixel_col (o_pixel_col),
    .o_hit_mask  (o_hit_mask)
);
